/* hw/rtl/hdlcdf_pkg.sv */
// Shared types, codes and the byte-wide CRC-16 step for the HDLC byte deframer.
// No dependencies; hdlc_byte_deframer.sv in hw/rtl imports this package.
package hdlcdf_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // End-of-frame status codes
  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_FCS_ERR   = 2'd1;
  localparam logic [1:0] ST_TOO_SHORT = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  frame_byte;
    logic [1:0]  end_status;
    logic [15:0] payload_len;
    logic [15:0] info_len;
  } result_t;

  // One byte through CRC-16/CCITT, MSB first, no final inversion
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/hdlcdf_if.sv */
// Valid/ready channel interfaces for the HDLC byte deframer: raw line bytes in,
// result items out. Depends on nothing else.
interface hdlcdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface hdlcdf_result_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  frame_byte;
  logic [1:0]  end_status;
  logic [15:0] payload_len;
  logic [15:0] info_len;

  modport source (output valid, output item_kind, output frame_byte, output end_status,
                  output payload_len, output info_len, input ready);
  modport sink   (input valid, input item_kind, input frame_byte, input end_status,
                  input payload_len, input info_len, output ready);
endinterface

/* hw/rtl/hdlc_byte_deframer.sv */
// HDLC asynchronous byte deframer: unstuffing, address filter, CRC-16 check.
// Depends on hdlcdf_pkg and the channel interfaces in hdlcdf_if.sv.
//
//   channel    dir   payload                                          beat when
//   line_in    in    line_byte[7:0]                                   valid & ready
//   frame_out  out   item_kind, frame_byte, end_status,               valid & ready
//                    payload_len, info_len
//   cfg        in    cfg_index[2:0], cfg_wdata[15:0]                  cfg_wr_en
//
// One line byte is taken every cycle while the input is not stalled; each beat is
// decoded combinationally and its result, if any, is registered into the output
// register, or into the skid entry while the output stalls. A one-entry skid stage
// behind the output register sets the throughput: the input stalls only once both
// the output register and the skid entry are full. rst is synchronous, active high:
// hunt phase, empty output, registers at their reset values.
module hdlc_byte_deframer (
  input  logic                                   clk,
  input  logic                                   rst,
  hdlcdf_byte_if.sink                            line_in,
  hdlcdf_result_if.source                        frame_out,
  input  logic                                   cfg_wr_en,
  input  logic [hdlcdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hdlcdf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import hdlcdf_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_ESC  = 2'd3
  } phase_t;

  // Configuration registers
  logic [7:0]  own_address;
  logic [7:0]  partner_address;
  logic [7:0]  broadcast_address;
  logic [15:0] frame_capacity;
  logic [4:0]  shortest_frame;
  logic [15:0] crc_seed;

  // Frame state
  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  hold0, hold1;       // two-byte window; the newest pair is the FCS at close

  // Output register and skid entry
  logic        out_valid;
  result_t     out_data;
  logic        skid_valid;
  result_t     skid_data;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic [7:0]  ub;                 // unstuffed byte
  logic        hold0_we, hold1_we;
  logic [7:0]  hold0_d;
  logic [15:0] pl, il;
  logic        addr_ok;

  assign line_in.ready = !skid_valid;
  assign accept        = line_in.valid && line_in.ready;

  assign frame_out.valid       = out_valid;
  assign frame_out.item_kind   = out_data.item_kind;
  assign frame_out.frame_byte  = out_data.frame_byte;
  assign frame_out.end_status  = out_data.end_status;
  assign frame_out.payload_len = out_data.payload_len;
  assign frame_out.info_len    = out_data.info_len;

  // Byte decode: one pass per beat
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    res_valid        = 1'b0;
    res              = '0;
    hold0_we         = 1'b0;
    hold1_we         = 1'b0;
    hold0_d          = 8'h00;
    ub      = (phase == PH_ESC) ? (line_in.line_byte ^ ESC_MASK) : line_in.line_byte;
    pl      = byte_count - 16'd2;
    il      = (pl > 16'd2) ? (pl - 16'd2) : 16'd0;
    addr_ok = (ub == own_address) || (ub == partner_address) || (ub == broadcast_address);

    if (line_in.line_byte == FLAG_BYTE) begin
      // Close any open frame with stored bytes, then open a new one
      if (phase != PH_HUNT && byte_count != 16'd0) begin
        res_valid      = 1'b1;
        res.item_kind  = KIND_END;
        if (byte_count >= 16'd2 && byte_count >= {11'd0, shortest_frame}) begin
          res.end_status  = (running_crc == {hold0, hold1}) ? ST_GOOD : ST_FCS_ERR;
          res.payload_len = pl;
          res.info_len    = il;
        end else begin
          res.end_status  = ST_TOO_SHORT;
        end
      end
      phase_next       = PH_ADDR;
      byte_count_next  = 16'd0;
      running_crc_next = crc_seed;
    end else if (phase == PH_HUNT) begin
      // drop everything until a flag
    end else if (line_in.line_byte == ESC_BYTE) begin
      phase_next = PH_ESC;
    end else if (byte_count >= frame_capacity) begin
      res_valid      = 1'b1;
      res.item_kind  = KIND_END;
      res.end_status = ST_OVERFLOW;
      phase_next     = PH_HUNT;
    end else if (byte_count == 16'd0) begin
      if (addr_ok) begin
        hold0_we        = 1'b1;
        hold0_d         = ub;
        byte_count_next = 16'd1;
        phase_next      = PH_DATA;
      end else begin
        phase_next = PH_HUNT;
      end
    end else begin
      phase_next      = PH_DATA;
      hold1_we        = 1'b1;
      byte_count_next = byte_count + 16'd1;
      if (byte_count != 16'd1) begin
        // Release the oldest held byte and fold it into the CRC
        res_valid        = 1'b1;
        res.item_kind    = KIND_BYTE;
        res.frame_byte   = hold0;
        running_crc_next = crc_byte(running_crc, hold0);
        hold0_we         = 1'b1;
        hold0_d          = hold1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= 8'd1;
      partner_address   <= 8'd2;
      broadcast_address <= 8'd255;
      frame_capacity    <= 16'd256;
      shortest_frame    <= 5'd4;
      crc_seed          <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_ADDR:   own_address       <= cfg_wdata[7:0];
        CFG_PEER_ADDR:  partner_address   <= cfg_wdata[7:0];
        CFG_BCAST_ADDR: broadcast_address <= cfg_wdata[7:0];
        CFG_CAPACITY:   frame_capacity    <= cfg_wdata;
        CFG_SHORTEST:   shortest_frame    <= cfg_wdata[4:0];
        CFG_CRC_SEED:   crc_seed          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state: advance on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= 16'd0;
      running_crc <= 16'hFFFF;
    end else if (accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  // Hold window: no reset, read only once written in the current frame
  always_ff @(posedge clk) begin
    if (accept && hold0_we) begin
      hold0 <= hold0_d;
    end
    if (accept && hold1_we) begin
      hold1 <= ub;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (frame_out.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_out.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && res_valid) begin
        out_data <= res;
      end
    end else if (accept && res_valid) begin
      skid_data <= res;
    end
  end

`ifndef SYNTHESIS
  // The skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // A result produced while the output stalls must land in the skid entry
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && out_valid && !frame_out.ready) |=> skid_valid)
    else $error("result lost while output stalled");

  // Frame bytes carry no status or lengths
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.item_kind == KIND_BYTE) |->
      (out_data.end_status == ST_GOOD && out_data.payload_len == 16'd0 &&
       out_data.info_len == 16'd0))
    else $error("frame byte result with status or length set");

  // Too short and overflow ends report zero lengths
  a_bad_end_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.item_kind == KIND_END &&
     (out_data.end_status == ST_TOO_SHORT || out_data.end_status == ST_OVERFLOW)) |->
      (out_data.payload_len == 16'd0 && out_data.info_len == 16'd0))
    else $error("short or overflow end with non-zero length");
`endif

endmodule

/* tb/sv/hdlc_byte_deframer_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for hdlc_byte_deframer: stuffed line bytes in, frame bytes and
// end-of-frame status out, checked against an in-bench deframer model.
// Depends on hdlcdf_pkg, the channel interfaces in hdlcdf_if.sv and the block itself.
module hdlc_byte_deframer_tb;
  import hdlcdf_pkg::*;

  localparam int SEG_BYTES     = 160;     // line bytes queued per random segment
  localparam int SETTLE_CYCLES = 8;       // quiet cycles before a register write or the end
  localparam int LIMIT_CYCLES  = 400000;  // hard stop, far beyond the slowest clean run

  // Receive phase of the deframer model
  typedef enum logic [1:0] {RX_HUNT, RX_ADDR, RX_DATA, RX_ESC} rx_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hdlcdf_byte_if   line_if ();
  hdlcdf_result_if frame_if ();

  hdlc_byte_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_if),
    .frame_out (frame_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model copy of the configuration registers, reset values first
  logic [7:0]  addr_own      = 8'd1;
  logic [7:0]  addr_peer     = 8'd2;
  logic [7:0]  addr_bcast    = 8'd255;
  logic [15:0] frame_cap     = 16'd256;
  logic [4:0]  min_frame_len = 5'd4;
  logic [15:0] crc_preset    = 16'hFFFF;

  // Model receive state
  rx_phase_t   rx_phase = RX_HUNT;
  logic [15:0] rx_count = '0;
  logic [15:0] rx_crc   = 16'hFFFF;
  logic [7:0]  rx_hold [2];

  logic [7:0] line_bytes [$];   // line bytes waiting for the driver
  result_t    awaited [$];      // results the block still owes, oldest first
  logic [7:0] frame_body [$];   // unstuffed frame under construction

  int send_idle_pct = 35;
  int recv_idle_pct = 85;
  int mismatch_count = 0;
  int cycle_count = 0;

  // CRC-16/CCITT, one bit at a time, MSB first
  function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] data);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ data[k];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  // Advance the deframer model by one accepted line byte; queue any result it owes.
  function automatic void deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    result_t r;
    b = raw;
    r = '0;
    if (raw == FLAG_BYTE) begin
      // A flag closes whatever was collected; empty frames and hunt flags stay silent
      if (rx_phase != RX_HUNT && rx_count != 0) begin
        r.item_kind = KIND_END;
        if (rx_count >= 2 && rx_count >= {11'd0, min_frame_len}) begin
          r.payload_len = rx_count - 16'd2;
          r.info_len    = (rx_count > 16'd4) ? rx_count - 16'd4 : 16'd0;
          r.end_status  = (rx_crc == {rx_hold[0], rx_hold[1]}) ? ST_GOOD : ST_FCS_ERR;
        end else begin
          r.end_status = ST_TOO_SHORT;
        end
        awaited.push_back(r);
      end
      rx_phase = RX_ADDR;
      rx_count = '0;
      rx_crc   = crc_preset;
      return;
    end
    if (rx_phase == RX_HUNT) return;
    if (raw == ESC_BYTE) begin
      // a second escape simply keeps the first one pending
      rx_phase = RX_ESC;
      return;
    end
    if (rx_phase == RX_ESC) begin
      b = b ^ ESC_MASK;
      rx_phase = RX_DATA;
    end
    if (rx_count >= frame_cap) begin
      r.item_kind  = KIND_END;
      r.end_status = ST_OVERFLOW;
      awaited.push_back(r);
      rx_phase = RX_HUNT;
      return;
    end
    if (rx_count == 0) begin
      if (b != addr_own && b != addr_peer && b != addr_bcast) begin
        rx_phase = RX_HUNT;
        return;
      end
      rx_hold[0] = b;
      rx_count   = 16'd1;
      rx_phase   = RX_DATA;
      return;
    end
    if (rx_count == 1) begin
      rx_hold[1] = b;
    end else begin
      // oldest held byte leaves the window and enters the CRC
      r.item_kind  = KIND_BYTE;
      r.frame_byte = rx_hold[0];
      awaited.push_back(r);
      rx_crc     = fcs_update(rx_crc, rx_hold[0]);
      rx_hold[0] = rx_hold[1];
      rx_hold[1] = b;
    end
    rx_count = rx_count + 16'd1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  // Compare one received result beat with the oldest expectation
  task automatic check_result();
    result_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0b byte %0h status %0d",
                                frame_if.item_kind, frame_if.frame_byte,
                                frame_if.end_status));
      return;
    end
    want = awaited.pop_front();
    compare_field("item_kind",   {15'd0, frame_if.item_kind},  {15'd0, want.item_kind});
    compare_field("frame_byte",  {8'd0, frame_if.frame_byte},  {8'd0, want.frame_byte});
    compare_field("end_status",  {14'd0, frame_if.end_status}, {14'd0, want.end_status});
    compare_field("payload_len", frame_if.payload_len,         want.payload_len);
    compare_field("info_len",    frame_if.info_len,            want.info_len);
  endtask

  // Frame content leaning towards the bytes that matter for stuffing and the extremes
  function automatic logic [7:0] pick_content();
    case ($urandom_range(11))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return FLAG_BYTE ^ ESC_MASK;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Stuff one frame byte onto the line; now and then escape a byte that needs no escape
  function automatic void push_stuffed(input logic [7:0] b);
    logic [7:0] flipped;
    flipped = b ^ ESC_MASK;
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        ($urandom_range(7) == 0 && flipped != FLAG_BYTE && flipped != ESC_BYTE)) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(flipped);
    end else begin
      line_bytes.push_back(b);
    end
  endfunction

  // Append the FCS over frame_body (seeded from the current preset), optionally damage
  // one bit, then stuff the lot onto the line. No flags are added here.
  function automatic void queue_body(input bit with_fcs, input bit corrupt);
    logic [15:0] acc;
    int pos;
    int bit_no;
    acc = crc_preset;
    foreach (frame_body[i]) acc = fcs_update(acc, frame_body[i]);
    if (with_fcs) begin
      frame_body.push_back(acc[15:8]);
      frame_body.push_back(acc[7:0]);
    end
    if (corrupt) begin
      pos    = $urandom_range(frame_body.size() - 1);
      bit_no = $urandom_range(7);
      frame_body[pos][bit_no] = ~frame_body[pos][bit_no];
    end
    foreach (frame_body[i]) push_stuffed(frame_body[i]);
    frame_body.delete();
  endfunction

  // One random frame closed by a flag: mostly well formed, the rest noise, bad
  // addresses, short frames, damaged FCS and escapes dangling at the closing flag.
  function automatic void queue_random_frame();
    int pick;
    int extra;
    logic [7:0] addr;
    pick = $urandom_range(99);
    if (pick < 10) begin
      extra = $urandom_range(1, 8);
      repeat (extra) begin
        line_bytes.push_back(($urandom_range(9) == 0) ? FLAG_BYTE : pick_content());
      end
    end else begin
      case ($urandom_range(2))
        0:       addr = addr_own;
        1:       addr = addr_peer;
        default: addr = addr_bcast;
      endcase
      if (pick < 18) addr = 8'($urandom_range(255));
      extra = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
      if (pick >= 18 && pick < 25) extra = $urandom_range(0, 2);
      frame_body.push_back(addr);
      repeat (extra) frame_body.push_back(pick_content());
      queue_body(pick >= 25, pick >= 25 && pick < 35);
      if (pick >= 35 && pick < 42) begin
        repeat ($urandom_range(1, 2)) line_bytes.push_back(ESC_BYTE);
      end
    end
    line_bytes.push_back(FLAG_BYTE);
    // sometimes open the next frame with its own flag, sometimes share the closing one
    if ($urandom_range(1) == 1) line_bytes.push_back(FLAG_BYTE);
  endfunction

  // Hold until the line queue is empty, no beat is on offer and no result is owed,
  // then let the block settle. Sample just after the edge so the state is stable.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (line_bytes.size() != 0 || line_if.valid || awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per edge; the model copy follows straight away since the
  // block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_OWN_ADDR:   addr_own      = value[7:0];
      CFG_PEER_ADDR:  addr_peer     = value[7:0];
      CFG_BCAST_ADDR: addr_bcast    = value[7:0];
      CFG_CAPACITY:   frame_cap     = value;
      CFG_SHORTEST:   min_frame_len = value[4:0];
      CFG_CRC_SEED:   crc_preset    = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] own, input logic [7:0] peer,
                                input logic [7:0] bcast, input logic [15:0] cap,
                                input logic [4:0] shortest, input logic [15:0] seed);
    write_reg(CFG_OWN_ADDR,   {8'd0, own});
    write_reg(CFG_PEER_ADDR,  {8'd0, peer});
    write_reg(CFG_BCAST_ADDR, {8'd0, bcast});
    write_reg(CFG_CAPACITY,   cap);
    write_reg(CFG_SHORTEST,   {11'd0, shortest});
    write_reg(CFG_CRC_SEED,   seed);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Line driver: predict each accepted beat, then offer the next byte or idle.
  // valid only drops or changes once the beat on offer has been taken.
  always @(posedge clk) begin
    if (rst) begin
      line_if.valid <= 1'b0;
    end else begin
      if (line_if.valid && line_if.ready) deframe_byte(line_if.line_byte);
      if (!line_if.valid || line_if.ready) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          line_if.valid     <= 1'b1;
          line_if.line_byte <= line_bytes.pop_front();
        end else begin
          line_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check every accepted beat and stall at random
  always @(posedge clk) begin
    if (rst) begin
      frame_if.ready <= 1'b0;
    end else begin
      if (frame_if.valid && frame_if.ready) check_result();
      frame_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("hdlc_byte_deframer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    // Drive every input to a known value before the first edge
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    line_if.valid      = 1'b0;
    line_if.line_byte  = '0;
    frame_if.ready     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings: stray byte while hunting, flag in hunt,
    // repeated flag, stuffed good frame with both byte extremes, rejected address,
    // one-byte frame, double escape left pending at the flag, and a bad FCS on a
    // frame too small to carry information.
    line_bytes.push_back(8'h00);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    frame_body.push_back(8'hFF);
    frame_body.push_back(FLAG_BYTE);
    frame_body.push_back(ESC_BYTE);
    frame_body.push_back(8'h00);
    queue_body(1'b1, 1'b0);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(8'h55);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(8'h02);
    line_bytes.push_back(ESC_BYTE);
    line_bytes.push_back(ESC_BYTE);
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(8'h03);
    line_bytes.push_back(8'h04);
    line_bytes.push_back(8'h05);
    line_bytes.push_back(FLAG_BYTE);
    wait_idle();

    // Random segments, each on its own settings. Sender light / receiver heavy idling
    // first, then swapped, then no idling at all.
    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 85 : 0;
      recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 35 : 0;
      case (seg)
        0: apply_settings(8'h00, FLAG_BYTE, 8'hFF, 16'd4, 5'd4, 16'h0000);
        1: apply_settings(ESC_BYTE, 8'h80, 8'h55, 16'hFFFF, 5'd16, 16'hFFFF);
        2: apply_settings(8'h01, 8'h02, 8'hFF, 16'd12, 5'd5, 16'h1D0F);
        4: apply_settings(8'hAA, 8'h03, 8'h00, 16'd20, 5'd6, 16'h8005);
        default: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 16'($urandom_range(4, 48)),
                                5'($urandom_range(4, 16)), 16'($urandom_range(65535)));
      endcase
      line_bytes.push_back(FLAG_BYTE);
      if (seg == 0) begin
        // capacity of four: the fifth byte overflows, hunt until the next flag
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'h01);
        line_bytes.push_back(8'h02);
        line_bytes.push_back(8'h03);
        line_bytes.push_back(8'h04);
        line_bytes.push_back(8'h09);
        line_bytes.push_back(FLAG_BYTE);
      end
      while (line_bytes.size() < SEG_BYTES) begin
        queue_random_frame();
        // once, hold the sender until every owed result is out
        if (seg == 4 && !paused && line_bytes.size() >= SEG_BYTES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("hdlc_byte_deframer_tb: done, clean");
    end else begin
      $display("hdlc_byte_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
